// File: hdl/sha_pkg.sv
// Shared types, constants and the rotate function of the SHA-256 hasher.
package sha_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = 2;

  // One classified input item as it travels from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } item_t;

  localparam logic [WordW-1:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// File: hdl/sha256_message_hasher.sv
// Top level of the streaming SHA-256 message hasher.
// Usage:
//   Input channel s_axis: one transfer per message byte. tuser[0] says the
//   byte is present, tlast marks the final item of a message. A final item
//   without a byte ends the message (an empty message when it comes alone).
//   Items with neither byte nor tlast are dropped.
//   Output channel m_axis: eight transfers per message, digest word 0 first,
//   tlast on word 7, tuser holding the word index.
// Operation: each byte is taken from the queue and packed; each full 64-byte
//   block is compressed (64 rounds plus the chaining add). The end of a
//   message adds padding, one byte a cycle between compressions, and one or two blocks.
//   A four-entry queue takes input while the back end compresses.
// Reset clears the queue, the length, the byte slot and loads the initial
//   hash constants. When the receiver stalls, the current digest word is
//   held and the back end waits; the queue keeps taking input until full.
module sha256_message_hasher import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // msg_byte
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_index
  output logic        m_axis_tlast    // last_word
);

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  assign in_item = '{data: s_axis_tdata, has_byte: s_axis_tuser, last: s_axis_tlast};

  sha_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item,
    .q_valid, .q_ready, .q_item
  );

  sha_core u_core (
    .clk, .rst,
    .q_valid, .q_ready, .q_item,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .digest_word(m_axis_tdata), .word_index(m_axis_tuser), .last_word(m_axis_tlast)
  );

endmodule

// File: hdl/sha_front.sv
// Input stage: takes stream transfers, drops empty items and queues the rest.
module sha_front import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  output logic       q_valid,
  input  logic       q_ready,
  output item_t      q_item
);

  item_t                store [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;
  logic                 push;
  logic                 pop;

  assign in_ready = (count != QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth));
  // Items carrying neither a byte nor an end mark have no effect at all.
  assign push     = in_valid && in_ready && (in_item.has_byte || in_item.last);
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        store[wr_ptr] <= in_item;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QueuePtrW+1)'(QueueDepth)) else $error("queue overfilled");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count did not grow");

endmodule

// File: hdl/sha_core.sv
// Back end: packs bytes, pads, runs the 64-round compression and emits the digest.
module sha_core import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_BYTE, S_PAD, S_ROUND, S_ADD, S_EMIT
  } state_t;

  state_t            state;
  logic [31:0]       hv [8];
  logic [31:0]       w  [16];
  logic [31:0]       wv [8];
  logic [5:0]        pos;
  logic [63:0]       bit_len;
  logic [6:0]        round;
  logic [7:0]        cur_byte;
  logic              finishing;
  logic              pad_started;
  logic              len_due;
  logic [63:0]       len_latch;
  logic [2:0]        emit_idx;

  logic [31:0]       wt, s0, s1, t1, t2, w15, w2;
  logic [31:0]       packed_word;
  logic [7:0]        pad_byte;
  logic [7:0]        next_byte;

  always_comb begin
    w15 = w[1];
    w2  = w[14];
    s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    // The schedule window shifts every round, so w[0] is always the current word.
    wt  = w[0];
    t1  = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25))
        + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + RoundK[round[5:0]] + wt;
    t2  = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22))
        + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
    packed_word = w[pos[5:2]];
    // Length bytes go only into the final block; a pad mark that landed in the
    // last eight slots is followed by zeros and one more block.
    if (!pad_started) begin
      pad_byte = PadByte;
    end else if (pos < 6'd56 || !len_due) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = len_latch[8*(7-pos[2:0]) +: 8];
    end
    next_byte = (state == S_BYTE) ? cur_byte : pad_byte;
  end

  assign q_ready     = (state == S_IDLE);
  assign out_valid   = (state == S_EMIT);
  assign digest_word = hv[emit_idx];
  assign word_index  = emit_idx;
  assign last_word   = (emit_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos         <= '0;
      bit_len     <= '0;
      round       <= '0;
      finishing   <= 1'b0;
      pad_started <= 1'b0;
      len_due     <= 1'b0;
      emit_idx    <= '0;
      for (int i = 0; i < 8; i++) hv[i] <= InitHash[i];
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_byte  <= q_item.data;
            finishing <= q_item.last;
            if (q_item.has_byte) begin
              bit_len <= bit_len + 64'd8;
              state   <= S_BYTE;
            end else begin
              len_latch   <= bit_len;
              pad_started <= 1'b0;
              len_due     <= 1'b0;
              state       <= S_PAD;
            end
          end
        end
        S_BYTE, S_PAD: begin
          w[pos[5:2]] <= (pos[1:0] == 2'd0) ? {next_byte, 24'h0}
                       : packed_word | ({24'h0, next_byte} << (8 * (3 - pos[1:0])));
          pos <= pos + 1'b1;
          if (state == S_PAD) pad_started <= 1'b1;
          if (state == S_PAD && !pad_started) len_due <= (pos < 6'd56);
          if (state == S_BYTE && finishing) begin
            len_latch   <= bit_len;
            pad_started <= 1'b0;
            len_due     <= 1'b0;
          end
          if (pos == 6'd63) begin
            for (int i = 0; i < 8; i++) wv[i] <= hv[i];
            round <= '0;
            state <= S_ROUND;
          end else if (state == S_BYTE) begin
            if (finishing) begin
              state <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w[0] + s0 + w[9] + s1;
          wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          round <= round + 1'b1;
          if (round == 7'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) hv[i] <= hv[i] + wv[i];
          round <= '0;
          // A block that ended on the length bytes completes the message.
          if (finishing && pad_started && len_due) begin
            state    <= S_EMIT;
            emit_idx <= '0;
          end else if (finishing) begin
            len_due <= 1'b1;
            state   <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hv[i] <= InitHash[i];
              bit_len     <= '0;
              pos         <= '0;
              finishing   <= 1'b0;
              pad_started <= 1'b0;
              len_due     <= 1'b0;
              state       <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(emit_idx)) else $error("digest dropped");
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> round < 7'd64) else $error("round overrun");
  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> emit_idx == 3'd0) else $error("digest starts mid-way");

endmodule
